// ----- hdl/spf_pkg.sv -----
`default_nettype none

package spf_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'hAA;
    localparam logic [15:0] SEQ_BYTES  = 16'd4;
    localparam logic [7:0]  FORCED_SUM = 8'h00;

    localparam int unsigned PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_SYNC   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ID     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_LO = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SEQ3   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SEQ2   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SEQ1   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SEQ0   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DATA   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SUM    = 4'd9;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } word_t;

endpackage

`default_nettype wire

// ----- hdl/spf_in_if.sv -----
`default_nettype none

interface spf_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] packet_id;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       force_bad_checksum;

    modport source (
        output valid,
        input  ready,
        output packet_id,
        output payload_length,
        output payload_byte,
        output last_byte,
        output force_bad_checksum
    );

    modport sink (
        input  valid,
        output ready,
        input  packet_id,
        input  payload_length,
        input  payload_byte,
        input  last_byte,
        input  force_bad_checksum
    );

endinterface

`default_nettype wire

// ----- hdl/spf_out_if.sv -----
`default_nettype none

interface spf_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_frame;

    modport source (
        output valid,
        input  ready,
        output out_byte,
        output end_of_frame
    );

    modport sink (
        input  valid,
        output ready,
        input  out_byte,
        input  end_of_frame
    );

endinterface

`default_nettype wire

// ----- hdl/spf_gen.sv -----
`default_nettype none

module spf_gen
    import spf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 247
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    spf_in_if.sink    item,
    output word_t     word,
    output logic      word_valid,
    input  wire logic word_ready
);

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    logic               work_valid_reg, work_valid_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         id_reg;
    logic [7:0]         plen_reg;
    logic [7:0]         data_reg;
    logic               last_reg;
    logic               force_in_reg;
    logic [31:0]        seq_reg, seq_next;
    logic [7:0]         sum_reg, sum_next;
    logic               inside_reg, inside_next;
    logic               force_reg, force_next;

    logic               emit;
    logic               finish;
    logic               accept;
    logic [15:0]        plen_wide;
    logic [15:0]        plen_clamp;
    logic [15:0]        frame_len;

    assign emit   = work_valid_reg && word_ready;
    assign finish = emit && ((phase_reg == PH_SUM) || ((phase_reg == PH_DATA) && !last_reg));
    assign item.ready = !work_valid_reg || finish;
    assign accept = item.valid && item.ready;

    assign plen_wide = {8'd0, plen_reg};

    always_comb
    begin
        if (plen_reg == 8'd0)
        begin
            plen_clamp = 16'd1;
        end
        else if (plen_wide > MaxLen)
        begin
            plen_clamp = MaxLen;
        end
        else
        begin
            plen_clamp = plen_wide;
        end
        frame_len = plen_clamp + SEQ_BYTES;
    end

    always_comb
    begin
        word.end_of_frame = 1'b0;
        unique case (phase_reg)
            PH_SYNC:   word.out_byte = SYNC_BYTE;
            PH_ID:     word.out_byte = id_reg;
            PH_LEN_HI: word.out_byte = frame_len[15:8];
            PH_LEN_LO: word.out_byte = frame_len[7:0];
            PH_SEQ3:   word.out_byte = seq_reg[31:24];
            PH_SEQ2:   word.out_byte = seq_reg[23:16];
            PH_SEQ1:   word.out_byte = seq_reg[15:8];
            PH_SEQ0:   word.out_byte = seq_reg[7:0];
            PH_DATA:   word.out_byte = data_reg;
            PH_SUM:
            begin
                word.out_byte     = force_reg ? FORCED_SUM : sum_reg;
                word.end_of_frame = 1'b1;
            end
            default:   word.out_byte = 8'd0;
        endcase
    end

    assign word_valid = work_valid_reg;

    always_comb
    begin
        seq_next    = seq_reg;
        sum_next    = sum_reg;
        inside_next = inside_reg;
        force_next  = force_reg;
        if (emit)
        begin
            if (phase_reg == PH_SYNC)
            begin
                force_next = force_in_reg;
            end
            if ((phase_reg >= PH_SEQ3) && (phase_reg <= PH_DATA))
            begin
                sum_next = sum_reg + word.out_byte;
            end
            if (phase_reg == PH_DATA)
            begin
                inside_next = 1'b1;
            end
            if (phase_reg == PH_SUM)
            begin
                seq_next    = seq_reg + 32'd1;
                sum_next    = 8'd0;
                inside_next = 1'b0;
                force_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        phase_next      = phase_reg;
        if (accept)
        begin
            work_valid_next = 1'b1;
            phase_next      = inside_next ? PH_DATA : PH_SYNC;
        end
        else if (finish)
        begin
            work_valid_next = 1'b0;
        end
        else if (emit)
        begin
            phase_next = (phase_reg == PH_DATA) ? PH_SUM : phase_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            phase_reg      <= PH_SYNC;
            seq_reg        <= 32'd1;
            sum_reg        <= 8'd0;
            inside_reg     <= 1'b0;
            force_reg      <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            sum_reg        <= sum_next;
            inside_reg     <= inside_next;
            force_reg      <= force_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg       <= item.packet_id;
            plen_reg     <= item.payload_length;
            data_reg     <= item.payload_byte;
            last_reg     <= item.last_byte;
            force_in_reg <= item.force_bad_checksum;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/spf_obuf.sv -----
`default_nettype none

module spf_obuf
    import spf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire word_t  word,
    input  wire logic   word_valid,
    output logic        word_ready,
    spf_out_if.source   framed
);

    logic  valid_reg;
    word_t word_reg;

    assign word_ready = !valid_reg || framed.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (word_ready)
        begin
            valid_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
        begin
            word_reg <= word;
        end
    end

    assign framed.valid        = valid_reg;
    assign framed.out_byte     = word_reg.out_byte;
    assign framed.end_of_frame = word_reg.end_of_frame;

endmodule

`default_nettype wire

// ----- hdl/sequenced_packet_framer.sv -----
`default_nettype none

// Channel   Dir   Word
// item      in    packet_id, payload_length, payload_byte, last_byte, force_bad_checksum
// framed    out   out_byte, end_of_frame
//
// One output byte per cycle through the output register sets the pace while
// framed is ready. A frame's first byte comes after sync, id, length and
// sequence bytes, a last byte before the checksum; a single-byte frame has both.
// Reset opens no frame and sets the sequence number to 1.
// A stall on framed holds the output register and the current word; item
// is taken again as soon as the current word's last byte moves on.

module sequenced_packet_framer
    import spf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 247
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    spf_in_if.sink    item,
    spf_out_if.source framed
);

    word_t word;
    logic  word_valid;
    logic  word_ready;

    spf_gen #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .word       (word),
        .word_valid (word_valid),
        .word_ready (word_ready)
    );

    spf_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .framed     (framed)
    );

endmodule

`default_nettype wire
